FILE: sv/bso_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bso_pkg;

  localparam int unsigned CfgAddrW = 3;

  localparam logic [CfgAddrW-1:0] RegMinX = 3'd0;
  localparam logic [CfgAddrW-1:0] RegMinY = 3'd1;
  localparam logic [CfgAddrW-1:0] RegMinZ = 3'd2;
  localparam logic [CfgAddrW-1:0] RegMaxX = 3'd3;
  localparam logic [CfgAddrW-1:0] RegMaxY = 3'd4;
  localparam logic [CfgAddrW-1:0] RegMaxZ = 3'd5;

  typedef struct packed {
    logic prod_load;
    logic sum_load;
  } bso_load_t;

endpackage

`default_nettype wire

FILE: sv/bso_face.sv
`timescale 1ns / 1ps
`default_nettype none

module bso_face #(
  parameter int unsigned W = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  load_i,
  input  wire logic [2:0][W-1:0]     box_lo_i,
  input  wire logic [2:0][W-1:0]     box_hi_i,
  input  wire logic [2:0][W-1:0]     pt_s_i,
  input  wire logic [2:0][W-1:0]     pt_e_i,
  output logic      [2:0][W+1:0]     t_o,
  output logic      [2:0][W:0]       d_o,
  output logic      [2:0][W:0]       ad_o,
  output logic      [2:0][W:0]       ext_o,
  output logic                       ok_o
);

  logic [2:0] bad;
  logic [2:0] sep;
  logic       ok_q;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [W+1:0] lo2, hi2, s2, e2, t;
    logic signed [W:0]   d;
    logic        [W:0]   ext, ad;
    logic        [W+1:0] at;
    logic        [W+1:0] t_q;
    logic        [W:0]   d_q, ad_q, ext_q;

    assign lo2 = {{2{box_lo_i[a][W-1]}}, box_lo_i[a]};
    assign hi2 = {{2{box_hi_i[a][W-1]}}, box_hi_i[a]};
    assign s2  = {{2{pt_s_i[a][W-1]}}, pt_s_i[a]};
    assign e2  = {{2{pt_e_i[a][W-1]}}, pt_e_i[a]};

    assign bad[a] = $signed(box_lo_i[a]) > $signed(box_hi_i[a]);
    assign ext    = hi2[W:0] - lo2[W:0];
    assign d      = e2[W:0] - s2[W:0];
    assign t      = (lo2 + hi2) - (s2 + e2);
    assign ad     = d[W] ? -d : d;
    assign at     = t[W+1] ? -t : t;
    assign sep[a] = at > ({1'b0, ext} + {1'b0, ad});

    always_ff @(posedge clk_i) begin
      if (load_i) begin
        t_q   <= t;
        d_q   <= d;
        ad_q  <= ad;
        ext_q <= ext;
      end
    end

    assign t_o[a]   = t_q;
    assign d_o[a]   = d_q;
    assign ad_o[a]  = ad_q;
    assign ext_o[a] = ext_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ok_q <= ~|bad & ~|sep;
    end
  end

  assign ok_o = ok_q;

endmodule

`default_nettype wire

FILE: sv/bso_edge.sv
`timescale 1ns / 1ps
`default_nettype none

module bso_edge #(
  parameter int unsigned W = 32
) (
  input  wire logic               clk_i,
  input  wire bso_pkg::bso_load_t load_i,
  input  wire logic signed [W+1:0] t1_i,
  input  wire logic signed [W+1:0] t2_i,
  input  wire logic signed [W:0]   d1_i,
  input  wire logic signed [W:0]   d2_i,
  input  wire logic        [W:0]   ad1_i,
  input  wire logic        [W:0]   ad2_i,
  input  wire logic        [W:0]   e1_i,
  input  wire logic        [W:0]   e2_i,
  output logic                     sep_o
);

  localparam int unsigned PW = 2 * W + 3;
  localparam int unsigned QW = 2 * W + 2;

  logic signed [PW-1:0] pa_d, pb_d, pa_q, pb_q;
  logic        [QW-1:0] qa_d, qb_d, qa_q, qb_q;
  logic signed [PW:0]   diff;
  logic        [PW:0]   lhs_d, lhs_q;
  logic        [PW-1:0] rhs_d, rhs_q;

  // cross term and its bound
  assign pa_d = PW'(t1_i) * PW'(d2_i);
  assign pb_d = PW'(t2_i) * PW'(d1_i);
  assign qa_d = QW'(e1_i) * QW'(ad2_i);
  assign qb_d = QW'(e2_i) * QW'(ad1_i);

  always_ff @(posedge clk_i) begin
    if (load_i.prod_load) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      qa_q <= qa_d;
      qb_q <= qb_d;
    end
  end

  assign diff  = {pa_q[PW-1], pa_q} - {pb_q[PW-1], pb_q};
  assign lhs_d = diff[PW] ? -diff : diff;
  assign rhs_d = {1'b0, qa_q} + {1'b0, qb_q};

  always_ff @(posedge clk_i) begin
    if (load_i.sum_load) begin
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
    end
  end

  assign sep_o = lhs_q > {1'b0, rhs_q};

endmodule

`default_nettype wire

FILE: sv/box_segment_overlap_test_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      segment start and end points
// m_axis    out  m_axis_tvalid/tready      hit flag
// cfg       in   cfg_we_i                  box min and max corners
//
// one request per cycle sustained while the output is not stalled; a
// result passes through the four register stages in order (face tests,
// products, sums, final compare)
// reset clears the stage valid bits and the box registers to zero
// each stage holds while the next one is full and stalled

module box_segment_overlap_test_core #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // start_x, start_y, start_z, end_x, end_y, end_z
  input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // hit
  output logic [7:0]                            m_axis_tdata_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [bso_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  wire logic [COORD_WIDTH-1:0]           cfg_wdata_i
);

  localparam int unsigned W = COORD_WIDTH;

  logic [2:0][W-1:0] box_lo_q, box_hi_q;
  logic [2:0][W-1:0] pt_s, pt_e;
  logic [2:0][W+1:0] t;
  logic [2:0][W:0]   d, ad, ext;
  logic              ok1;
  logic              ok2_q, ok3_q, hit_q;
  logic              v1_q, v2_q, v3_q, v4_q;
  logic              rdy1, rdy2, rdy3, rdy4;
  logic [2:0]        sep;
  bso_pkg::bso_load_t load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_lo_q <= '0;
      box_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bso_pkg::RegMinX: box_lo_q[0] <= cfg_wdata_i;
        bso_pkg::RegMinY: box_lo_q[1] <= cfg_wdata_i;
        bso_pkg::RegMinZ: box_lo_q[2] <= cfg_wdata_i;
        bso_pkg::RegMaxX: box_hi_q[0] <= cfg_wdata_i;
        bso_pkg::RegMaxY: box_hi_q[1] <= cfg_wdata_i;
        bso_pkg::RegMaxZ: box_hi_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_unpack
    assign pt_s[a] = s_axis_tdata_i[a*W +: W];
    assign pt_e[a] = s_axis_tdata_i[(a+3)*W +: W];
  end

  assign rdy4 = !v4_q || m_axis_tready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign load.prod_load = rdy2;
  assign load.sum_load  = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  bso_face #(.W(W)) u_face (
    .clk_i    (clk_i),
    .load_i   (rdy1),
    .box_lo_i (box_lo_q),
    .box_hi_i (box_hi_q),
    .pt_s_i   (pt_s),
    .pt_e_i   (pt_e),
    .t_o      (t),
    .d_o      (d),
    .ad_o     (ad),
    .ext_o    (ext),
    .ok_o     (ok1)
  );

  bso_edge #(.W(W)) u_edge_x (
    .clk_i (clk_i), .load_i (load),
    .t1_i (t[1]), .t2_i (t[2]), .d1_i (d[1]), .d2_i (d[2]),
    .ad1_i (ad[1]), .ad2_i (ad[2]), .e1_i (ext[1]), .e2_i (ext[2]),
    .sep_o (sep[0])
  );

  bso_edge #(.W(W)) u_edge_y (
    .clk_i (clk_i), .load_i (load),
    .t1_i (t[2]), .t2_i (t[0]), .d1_i (d[2]), .d2_i (d[0]),
    .ad1_i (ad[2]), .ad2_i (ad[0]), .e1_i (ext[2]), .e2_i (ext[0]),
    .sep_o (sep[1])
  );

  bso_edge #(.W(W)) u_edge_z (
    .clk_i (clk_i), .load_i (load),
    .t1_i (t[0]), .t2_i (t[1]), .d1_i (d[0]), .d2_i (d[1]),
    .ad1_i (ad[0]), .ad2_i (ad[1]), .e1_i (ext[0]), .e2_i (ext[1]),
    .sep_o (sep[2])
  );

  always_ff @(posedge clk_i) begin
    if (rdy2) ok2_q <= ok1;
    if (rdy3) ok3_q <= ok2_q;
    if (rdy4) hit_q <= ok3_q & ~|sep;
  end

  assign s_axis_tready_o = rdy1;
  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = {7'b0, hit_q};

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (v1_q && v2_q && v3_q && v4_q && !m_axis_tready_i))
    else $error("input blocked while pipeline has room");

  a_request_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v1_q)
    else $error("accepted request missing from first stage");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !rdy3) |=> v3_q)
    else $error("stalled stage dropped its request");

endmodule

`default_nettype wire
